@@ sv/rrsp_pkg.sv @@
// rrsp_pkg: shared types and codes for the capability round-robin server picker
// no dependencies; imported by the cell and the top level
`timescale 1ns / 1ps

package rrsp_pkg;

	localparam int SID_W    = 4;
	localparam int FID_W    = 6;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;
	localparam int ID_COUNT = 1 << SID_W;

	// request types
	localparam logic [REQ_W-1:0] REQ_REG_SERVER = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REG_FUNC   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP     = 2'd2;

	// response status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	// command broadcast to every cell
	typedef struct packed {
		logic             exec;
		logic [REQ_W-1:0] req;
		logic [SID_W-1:0] sid;
		logic [FID_W-1:0] fidx;
		logic             func_ok;
	} cell_cmd_t;

	// per-cell status seen by the top level and the neighbor
	typedef struct packed {
		logic valid;
		logic match;
		logic hit;
		logic first;
	} cell_stat_t;

endpackage

@@ sv/rrsp_req_if.sv @@
// rrsp_req_if: request channel (valid/ready plus request word)
// depends on rrsp_pkg for field widths
`timescale 1ns / 1ps

interface rrsp_req_if;
	logic                      valid;
	logic                      ready;
	logic [rrsp_pkg::REQ_W-1:0] req_type;
	logic [rrsp_pkg::SID_W-1:0] server_id;
	logic [rrsp_pkg::FID_W-1:0] func_id;

	modport source (output valid, req_type, server_id, func_id, input ready);
	modport sink (input valid, req_type, server_id, func_id, output ready);
endinterface

@@ sv/rrsp_rsp_if.sv @@
// rrsp_rsp_if: response channel (valid/ready plus response word)
// depends on rrsp_pkg for field widths
`timescale 1ns / 1ps

interface rrsp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rrsp_pkg::STAT_W-1:0] status;
	logic [rrsp_pkg::SID_W-1:0]  chosen_server;

	modport source (output valid, status, chosen_server, input ready);
	modport sink (input valid, status, chosen_server, output ready);
endinterface

@@ sv/capability_round_robin_server_picker.sv @@
// channel  | dir | word                                  | handshake
// req      | in  | req_type[1:0] server_id[3:0] func_id[5:0] | valid/ready
// rsp      | out | status[1:0] chosen_server[3:0]        | valid/ready
//
// each request is first registered; in its execute cycle the cell row
// matches, updates (on a lookup it shifts the picked server to the back) and
// loads the response register. a new request is taken while the response
// still waits. a stalled response holds the execute cycle of the next request.
// reset clears the occupancy of every cell at once; no clearing pass.
// depends on rrsp_pkg, rrsp_req_if, rrsp_rsp_if and rrsp_cell
`timescale 1ns / 1ps

module capability_round_robin_server_picker #(
	parameter int MAX_SERVERS  = 16,
	parameter int NUM_FUNC_IDS = 64
) (
	input logic   clk,
	input logic   arst_n,
	rrsp_req_if.sink   req,
	rrsp_rsp_if.source rsp
);
	import rrsp_pkg::*;

	localparam int DEPTH = (MAX_SERVERS < ID_COUNT) ? MAX_SERVERS : ID_COUNT;
	localparam int FW    = (NUM_FUNC_IDS > 1) ? $clog2(NUM_FUNC_IDS) : 1;
	localparam int CAPW  = 1 << FW;

	logic              busy_q;
	logic [REQ_W-1:0]  req_q;
	logic [SID_W-1:0]  sid_q;
	logic [FID_W-1:0]  fid_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [SID_W-1:0]  chosen_q;

	logic              exec;
	cell_cmd_t         cmd;
	cell_stat_t        stat_arr [DEPTH];
	logic [SID_W-1:0]  sid_arr  [DEPTH];
	logic [CAPW-1:0]   caps_arr [DEPTH];
	logic [DEPTH-1:0]  valid_vec;
	logic [DEPTH-1:0]  match_vec;
	logic [DEPTH-1:0]  first_vec;
	logic              any_known;
	logic              any_hit;
	logic              full;
	logic [SID_W-1:0]  picked_sid;
	logic [CAPW-1:0]   picked_caps;
	logic [STAT_W-1:0] status_d;
	logic [SID_W-1:0]  chosen_d;

	// handshake
	assign req.ready     = !busy_q;
	assign exec          = busy_q && (!out_valid_q || rsp.ready);
	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.chosen_server = chosen_q;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.req_type;
			sid_q <= req.server_id;
			fid_q <= req.func_id;
		end
	end

	// command broadcast to the row
	assign cmd.exec    = exec;
	assign cmd.req     = req_q;
	assign cmd.sid     = sid_q;
	assign cmd.fidx    = fid_q;
	assign cmd.func_ok = ({1'b0, fid_q} < (FID_W + 1)'(NUM_FUNC_IDS));

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             prev_valid;
		logic             hit_in;
		logic             next_valid;
		logic [SID_W-1:0] next_sid;
		logic [CAPW-1:0]  next_caps;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign hit_in     = 1'b0;
		end else begin : g_body
			assign prev_valid = stat_arr[i-1].valid;
			assign hit_in     = stat_arr[i-1].hit;
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_sid   = picked_sid;
			assign next_caps  = picked_caps;
		end else begin : g_link
			assign next_valid = stat_arr[i+1].valid;
			assign next_sid   = sid_arr[i+1];
			assign next_caps  = caps_arr[i+1];
		end

		rrsp_cell #(
			.FW (FW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.any_known   (any_known),
			.any_hit     (any_hit),
			.prev_valid  (prev_valid),
			.hit_in      (hit_in),
			.next_valid  (next_valid),
			.next_sid    (next_sid),
			.next_caps   (next_caps),
			.picked_sid  (picked_sid),
			.picked_caps (picked_caps),
			.stat        (stat_arr[i]),
			.sid         (sid_arr[i]),
			.caps        (caps_arr[i])
		);
	end

	// gather row status and the picked slot
	always_comb begin
		picked_sid  = '0;
		picked_caps = '0;
		for (int i = 0; i < DEPTH; i++) begin
			valid_vec[i] = stat_arr[i].valid;
			match_vec[i] = stat_arr[i].match;
			first_vec[i] = stat_arr[i].first;
			picked_sid   = picked_sid | ({SID_W{stat_arr[i].first}} & sid_arr[i]);
			picked_caps  = picked_caps | ({CAPW{stat_arr[i].first}} & caps_arr[i]);
		end
	end

	assign any_known = |match_vec;
	assign any_hit   = stat_arr[DEPTH-1].hit;
	assign full      = stat_arr[DEPTH-1].valid;

	// response word
	always_comb begin
		status_d = ST_OK;
		chosen_d = '0;
		case (req_q)
			REQ_REG_SERVER: begin
				if (!any_known && full) begin
					status_d = ST_FULL;
				end
			end
			REQ_REG_FUNC: begin
				if (!any_known) begin
					status_d = ST_UNKNOWN;
				end
			end
			REQ_LOOKUP: begin
				if (any_hit) begin
					chosen_d = picked_sid;
				end else begin
					status_d = ST_NOMATCH;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= status_d;
			chosen_q <= chosen_d;
		end
	end

	// checks
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + DEPTH'(1))) == '0)
		else $error("occupied slots are not packed at the front");

	a_unique_id: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("server id held in more than one slot");

	a_single_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("more than one slot picked");

	a_lookup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && req_q == REQ_LOOKUP && any_hit) |=> (rsp.valid && rsp.status == ST_OK))
		else $error("lookup with a match did not answer ok");

	a_pick_known: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && req_q == REQ_LOOKUP && any_hit) |=> (valid_vec == $past(valid_vec)))
		else $error("lookup changed the list length");

endmodule

@@ sv/rrsp_cell.sv @@
// rrsp_cell: one slot of the service-order list with its server id and capability bitmap
// depends on rrsp_pkg; instantiated in a row by capability_round_robin_server_picker
`timescale 1ns / 1ps

module rrsp_cell #(
	parameter int FW = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rrsp_pkg::cell_cmd_t         cmd,
	input  logic                        any_known,
	input  logic                        any_hit,
	input  logic                        prev_valid,
	input  logic                        hit_in,
	input  logic                        next_valid,
	input  logic [rrsp_pkg::SID_W-1:0]  next_sid,
	input  logic [(1 << FW)-1:0]        next_caps,
	input  logic [rrsp_pkg::SID_W-1:0]  picked_sid,
	input  logic [(1 << FW)-1:0]        picked_caps,
	output rrsp_pkg::cell_stat_t        stat,
	output logic [rrsp_pkg::SID_W-1:0]  sid,
	output logic [(1 << FW)-1:0]        caps
);
	import rrsp_pkg::*;

	localparam int CAPW = 1 << FW;

	logic             valid_q;
	logic [SID_W-1:0] sid_q;
	logic [CAPW-1:0]  caps_q;
	logic             my_hit;
	logic             append;
	logic             rotate;

	// match and priority chain
	assign my_hit     = valid_q & cmd.func_ok & caps_q[cmd.fidx[FW-1:0]];
	assign stat.valid = valid_q;
	assign stat.match = valid_q && (sid_q == cmd.sid);
	assign stat.hit   = hit_in | my_hit;
	assign stat.first = my_hit & ~hit_in;
	assign sid        = sid_q;
	assign caps       = caps_q;

	// first empty slot takes a new server; slots at or after the pick shift forward
	assign append = cmd.exec && (cmd.req == REQ_REG_SERVER) && !any_known
		&& prev_valid && !valid_q;
	assign rotate = cmd.exec && (cmd.req == REQ_LOOKUP) && any_hit && stat.hit;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (append) begin
			valid_q <= 1'b1;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (append) begin
			sid_q  <= cmd.sid;
			caps_q <= '0;
		end else if (rotate) begin
			if (next_valid) begin
				sid_q  <= next_sid;
				caps_q <= next_caps;
			end else begin
				sid_q  <= picked_sid;
				caps_q <= picked_caps;
			end
		end else if (cmd.exec && (cmd.req == REQ_REG_FUNC) && stat.match && cmd.func_ok) begin
			caps_q[cmd.fidx[FW-1:0]] <= 1'b1;
		end
	end

endmodule

@@ tb/sv/capability_round_robin_server_picker_checker.sv @@
// checker for the capability round-robin server picker: watches both channels,
// predicts every response word and compares it; depends on rrsp_pkg and the two channel interfaces
`timescale 1ns / 1ps

module capability_round_robin_server_picker_checker #(
	parameter int MAX_SERVERS  = 16,
	parameter int NUM_FUNC_IDS = 64
) (
	input logic  clk,
	input logic  arst_n,
	rrsp_req_if  req,
	rrsp_rsp_if  rsp,
	output int   errors,
	output int   pending,
	output int   checked
);
	import rrsp_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SID_W-1:0]  chosen;
	} reply_t;

	// predicted picker state
	logic [SID_W-1:0] service_order [MAX_SERVERS];
	int               listed;
	logic             known [ID_COUNT];
	logic [63:0]      offers [ID_COUNT];

	reply_t expected_replies [$];

	assign pending = expected_replies.size();

	// apply one request to the predicted state and work out its reply
	task automatic serve_request(input logic [REQ_W-1:0] rt, input logic [SID_W-1:0] sid,
			input logic [FID_W-1:0] fid, output reply_t r);
		int               hit_pos;
		logic [SID_W-1:0] picked;
		r.status = ST_OK;
		r.chosen = '0;
		case (rt)
			REQ_REG_SERVER: begin
				// duplicates change nothing, a new id goes to the back
				if (!known[sid]) begin
					if (listed >= MAX_SERVERS) begin
						r.status = ST_FULL;
					end else begin
						service_order[listed] = sid;
						listed++;
						known[sid]  = 1'b1;
						offers[sid] = '0;
					end
				end
			end
			REQ_REG_FUNC: begin
				if (!known[sid])
					r.status = ST_UNKNOWN;
				else if (fid < NUM_FUNC_IDS)
					offers[sid][fid] = 1'b1;
			end
			REQ_LOOKUP: begin
				r.status = ST_NOMATCH;
				if (fid < NUM_FUNC_IDS) begin
					hit_pos = -1;
					for (int i = 0; i < listed; i++)
						if (hit_pos < 0 && offers[service_order[i]][fid])
							hit_pos = i;
					// first capable server moves to the back of the list
					if (hit_pos >= 0) begin
						picked = service_order[hit_pos];
						for (int j = hit_pos; j < listed - 1; j++)
							service_order[j] = service_order[j + 1];
						service_order[listed - 1] = picked;
						r.status = ST_OK;
						r.chosen = picked;
					end
				end
			end
			default: ;
		endcase
	endtask

	// predict on every accepted request, compare on every accepted response
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			listed  = 0;
			errors  = 0;
			checked = 0;
			for (int k = 0; k < ID_COUNT; k++) begin
				known[k]  = 1'b0;
				offers[k] = '0;
			end
			for (int k = 0; k < MAX_SERVERS; k++)
				service_order[k] = '0;
			expected_replies.delete();
		end else begin
			if (req.valid && req.ready) begin
				serve_request(req.req_type, req.server_id, req.func_id, want);
				expected_replies.insert(expected_replies.size(), want);
			end
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected response word, expected none, %s %0d server %0d",
						$time, "got status", rsp.status, rsp.chosen_server);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (rsp.chosen_server !== want.chosen) begin
						$display("%0t: chosen_server mismatch, expected %0d, got %0d",
							$time, want.chosen, rsp.chosen_server);
						errors++;
					end
				end
			end
		end
	end

endmodule

@@ tb/sv/capability_round_robin_server_picker_test.sv @@
// top of the server picker testbench: clock, reset, request and response drivers, verdict
// depends on rrsp_pkg, the channel interfaces, the block and its checker
`timescale 1ns / 1ps

module capability_round_robin_server_picker_test;
	import rrsp_pkg::*;

	localparam int MAX_SERVERS  = 16;
	localparam int NUM_FUNC_IDS = 64;
	localparam int RANDOM_WORDS = 1200;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

	logic clk;
	logic arst_n;
	int   err_count;
	int   open_replies;
	int   replies_seen;
	int   sent_by_type [4];
	logic steady;

	rrsp_req_if req_ch ();
	rrsp_rsp_if rsp_ch ();

	capability_round_robin_server_picker #(
		.MAX_SERVERS (MAX_SERVERS),
		.NUM_FUNC_IDS(NUM_FUNC_IDS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	capability_round_robin_server_picker_checker #(
		.MAX_SERVERS (MAX_SERVERS),
		.NUM_FUNC_IDS(NUM_FUNC_IDS)
	) checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.errors (err_count),
		.pending(open_replies),
		.checked(replies_seen)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit
	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	// offer a request word after a random gap unless steady, return at the edge that takes it
	task automatic send_word(input logic [REQ_W-1:0] rt, input logic [SID_W-1:0] sid,
			input logic [FID_W-1:0] fid);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rt;
		req_ch.server_id <= sid;
		req_ch.func_id   <= fid;
		do @(posedge clk); while (!req_ch.ready);
		sent_by_type[rt]++;
	endtask

	// response side: random stall after every taken word, none in steady phases
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				hold = steady ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int               pick;
		logic [REQ_W-1:0] rt;
		logic [FID_W-1:0] fid;
		steady           = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = '0;
		req_ch.server_id = '0;
		req_ch.func_id   = '0;
		for (int k = 0; k < 4; k++)
			sent_by_type[k] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, unknown server, duplicates, rotation, ignored type
		send_word(REQ_LOOKUP,     4'd0,  6'd0);
		send_word(REQ_REG_FUNC,   4'd5,  6'd0);
		send_word(REQ_REG_SERVER, 4'd0,  6'd63);
		send_word(REQ_REG_SERVER, 4'd15, 6'd0);
		send_word(REQ_REG_SERVER, 4'd0,  6'd0);
		send_word(REQ_REG_FUNC,   4'd0,  6'd63);
		send_word(REQ_REG_FUNC,   4'd15, 6'd63);
		send_word(REQ_REG_FUNC,   4'd15, 6'd0);
		send_word(REQ_LOOKUP,     4'd15, 6'd63);
		send_word(REQ_LOOKUP,     4'd0,  6'd63);
		send_word(REQ_LOOKUP,     4'd0,  6'd63);
		send_word(REQ_LOOKUP,     4'd15, 6'd0);
		send_word(REQ_LOOKUP,     4'd0,  6'd1);
		send_word(REQ_IGNORED,    4'd15, 6'd63);
		send_word(REQ_REG_FUNC,   4'd10, 6'd42);
		send_word(REQ_REG_SERVER, 4'd10, 6'd21);
		send_word(REQ_REG_FUNC,   4'd10, 6'd42);
		send_word(REQ_REG_FUNC,   4'd10, 6'd63);
		send_word(REQ_LOOKUP,     4'd5,  6'd42);
		send_word(REQ_LOOKUP,     4'd0,  6'd63);
		send_word(REQ_LOOKUP,     4'd0,  6'd63);
		send_word(REQ_LOOKUP,     4'd0,  6'd63);
		send_word(REQ_IGNORED,    4'd0,  6'd0);

		// random: lookup heavy, function ids often from a small pool so servers share them
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0)
				steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				rt = REQ_REG_SERVER;
			else if (pick < 30)
				rt = REQ_REG_FUNC;
			else if (pick < 95)
				rt = REQ_LOOKUP;
			else
				rt = REQ_IGNORED;
			fid = $urandom_range(0, 1) ? FID_W'($urandom_range(0, 7))
				: FID_W'($urandom_range(0, 63));
			send_word(rt, SID_W'($urandom_range(0, 15)), fid);
		end
		req_ch.valid <= 1'b0;
		steady = 1'b0;

		// drain once the last word is in the checker, then let the block settle
		@(posedge clk);
		while (open_replies != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d server registrations, %0d function registrations, %0d lookups, %0d ignored",
			sent_by_type[REQ_REG_SERVER], sent_by_type[REQ_REG_FUNC],
			sent_by_type[REQ_LOOKUP], sent_by_type[REQ_IGNORED]);
		$display("checked %0d response words with random gaps and stalls on both channels",
			replies_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/rrsp_pkg.sv
sv/rrsp_req_if.sv
sv/rrsp_rsp_if.sv
sv/rrsp_cell.sv
sv/capability_round_robin_server_picker.sv
tb/sv/capability_round_robin_server_picker_checker.sv
tb/sv/capability_round_robin_server_picker_test.sv
